>>> design/bmalloc_pkg.sv
// types and constants shared by the bitmap allocator and its checker
`default_nettype none

package bmalloc_pkg;

  localparam int unsigned ENTRY_W = 10;
  localparam int unsigned SIZE_W  = 11;
  localparam int unsigned RLOW_W  = 10;
  localparam int unsigned RHIGH_W = 11;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned CFGI_W  = 2;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BIT_W   = 5;

  typedef enum logic [1:0] {
    MODE_PLAIN   = 2'd0,
    MODE_WED     = 2'd1,
    MODE_WDS     = 2'd2,
    MODE_RELEASE = 2'd3
  } mode_e;

  typedef enum logic [CFGI_W-1:0] {
    CFG_ENTRIES_IN_USE = 2'd0,
    CFG_RESERVED_LOW   = 2'd1,
    CFG_RESERVED_HIGH  = 2'd2
  } cfg_idx_e;

  localparam logic [SIZE_W-1:0]  RST_ENTRIES_IN_USE = 11'd1024;
  localparam logic [RLOW_W-1:0]  RST_RESERVED_LOW   = 10'd256;
  localparam logic [RHIGH_W-1:0] RST_RESERVED_HIGH  = 11'd272;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FALLBACK,
    ST_RELEASE
  } state_e;

  // verdict on the word under scan
  typedef enum logic [1:0] {
    SCAN_NEXT,
    SCAN_TAKE,
    SCAN_FALLBACK,
    SCAN_FAIL
  } scan_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [ENTRY_W-1:0] entry_to_release;
  } req_t;

  typedef struct packed {
    logic               granted;
    logic [ENTRY_W-1:0] entry;
  } rsp_t;

endpackage

`default_nettype wire

>>> design/bitmap_id_allocator_reserved_range.sv
// bitmap first-free id allocator with a reserved range, word-serial memory scan
//
//   channel   signals                          direction  beat
//   request   start, busy, req_i               in         start & !busy
//   result    done_o, rsp_o                    out        done_o, one cycle
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i in         cfg_we_i
//
// allocation: one bitmap word read per cycle from word 0, scanning up to
// words = ceil(entries_in_use/32) words (capped at MAX_ENTRIES/32), then at most
// one fallback word; result in the cycle busy drops.
// release: one read-modify-write of the memory, busy for one cycle; failing
// release or zero entries in use: result next cycle, never busy.
// per-word valid bits make the bitmap read as zero after reset; the receiver cannot stall.
`default_nettype none

module bitmap_id_allocator_reserved_range #(
  parameter int unsigned MAX_ENTRIES = 1024
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 start,
  output logic                                busy,
  input  wire  bmalloc_pkg::req_t             req_i,
  output logic                                done_o,
  output bmalloc_pkg::rsp_t                   rsp_o,
  input  wire                                 cfg_we_i,
  input  wire  [bmalloc_pkg::CFGI_W-1:0]      cfg_idx_i,
  input  wire  [bmalloc_pkg::CFG_W-1:0]       cfg_wdata_i
);
  import bmalloc_pkg::*;

  localparam int unsigned NWORDS = MAX_ENTRIES / WORD_W;
  localparam int unsigned WIDX_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned CNT_W  = WIDX_W + 1;
  localparam int unsigned CUR_W  = WIDX_W + BIT_W;

  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (v[b]) r = BIT_W'(b);
    end
    return r;
  endfunction

  // configuration
  logic [SIZE_W-1:0]  size_q;
  logic [RLOW_W-1:0]  lo_q;
  logic [RHIGH_W-1:0] hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= RST_ENTRIES_IN_USE;
      lo_q   <= RST_RESERVED_LOW;
      hi_q   <= RST_RESERVED_HIGH;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ENTRIES_IN_USE: size_q <= cfg_wdata_i[SIZE_W-1:0];
        CFG_RESERVED_LOW:   lo_q   <= cfg_wdata_i[RLOW_W-1:0];
        CFG_RESERVED_HIGH:  hi_q   <= cfg_wdata_i[RHIGH_W-1:0];
        default: ;
      endcase
    end
  end

  // bitmap memory
  logic [WORD_W-1:0] mem [NWORDS];
  logic [NWORDS-1:0] wvalid_q;
  logic [WORD_W-1:0] rdata_q;
  logic              rvalid_q;
  logic [WIDX_W-1:0] rd_addr;
  logic              we;
  logic [WIDX_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvalid_q <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we) wvalid_q[waddr] <= 1'b1;
      rvalid_q <= wvalid_q[rd_addr];
    end
  end

  // control and working registers
  state_e             state_q, state_d;
  logic [WIDX_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]   words_q, words_d;
  logic [1:0]         mode_q, mode_d;
  logic [BIT_W-1:0]   rel_bit_q, rel_bit_d;
  logic               done_q, done_d;
  rsp_t               rsp_q, rsp_d;

  logic               accept;
  logic               rel_oob;
  logic [6:0]         words_raw;
  logic [CNT_W-1:0]   words_now;

  logic [WORD_W-1:0]  wd;
  logic [WORD_W-1:0]  free_bits;
  logic [BIT_W-1:0]   bit_idx;
  logic [CUR_W-1:0]   cur;
  logic               in_rsv;
  logic               beyond;
  logic               next_avail;
  logic               fb_ok;
  scan_e              verdict;

  logic [RHIGH_W-1:0] span;
  logic [WORD_W-1:0]  fb_allowed;
  logic [WORD_W-1:0]  fb_free;
  logic [BIT_W-1:0]   fb_bit;

  assign accept    = start && !busy;
  assign busy      = (state_q != ST_IDLE);
  assign rel_oob   = (32'(req_i.entry_to_release) >= MAX_ENTRIES);
  assign words_raw = 7'((12'(size_q) + 12'd31) >> BIT_W);
  assign words_now = (32'(words_raw) > NWORDS) ? CNT_W'(NWORDS) : CNT_W'(words_raw);

  // current word, unwritten words read as all free
  assign wd         = rvalid_q ? rdata_q : '0;
  assign free_bits  = ~wd;
  assign bit_idx    = lowest_set(free_bits);
  assign cur        = {idx_q, bit_idx};
  assign in_rsv     = (32'(cur) >= 32'(lo_q)) && (32'(cur) < 32'(hi_q));
  assign beyond     = (32'(cur) >= 32'(size_q));
  assign next_avail = (32'(idx_q) + 32'd1) < 32'(words_q);
  assign fb_ok      = (32'(hi_q) > 32'(lo_q)) && (32'(lo_q[RLOW_W-1:BIT_W]) < NWORDS);

  assign span       = hi_q - RHIGH_W'(lo_q);
  assign fb_allowed = (span >= RHIGH_W'(WORD_W)) ? '1
                    : ((WORD_W'(1) << span[BIT_W-1:0]) - WORD_W'(1));
  assign fb_free    = ~wd & fb_allowed;
  assign fb_bit     = lowest_set(fb_free);

  always_comb begin
    verdict = SCAN_NEXT;
    if (|free_bits) begin
      case (mode_e'(mode_q))
        MODE_WED: begin
          if (in_rsv)      verdict = SCAN_NEXT;
          else if (beyond) verdict = SCAN_FALLBACK;
          else             verdict = SCAN_TAKE;
        end
        MODE_WDS: begin
          if (32'(cur) < 32'(lo_q))       verdict = SCAN_NEXT;
          else if (32'(cur) >= 32'(hi_q)) verdict = SCAN_FAIL;
          else                            verdict = SCAN_TAKE;
        end
        default: begin
          if (beyond) verdict = SCAN_FAIL;
          else        verdict = SCAN_TAKE;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (mode_e'(req_i.mode) == MODE_RELEASE) begin
            state_d = rel_oob ? ST_IDLE : ST_RELEASE;
          end else begin
            state_d = (words_now == '0) ? ST_IDLE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        case (verdict)
          SCAN_NEXT:     state_d = next_avail ? ST_SCAN : ST_IDLE;
          SCAN_FALLBACK: state_d = fb_ok ? ST_FALLBACK : ST_IDLE;
          default:       state_d = ST_IDLE;
        endcase
      end
      ST_FALLBACK: state_d = ST_IDLE;
      ST_RELEASE:  state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath, memory access and result
  always_comb begin
    idx_d         = idx_q;
    words_d       = words_q;
    mode_d        = mode_q;
    rel_bit_d     = rel_bit_q;
    rd_addr       = idx_q;
    we            = 1'b0;
    waddr         = idx_q;
    wdata         = wd;
    done_d        = 1'b0;
    rsp_d         = rsp_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mode_d    = req_i.mode;
          words_d   = words_now;
          rel_bit_d = req_i.entry_to_release[BIT_W-1:0];
          if (mode_e'(req_i.mode) == MODE_RELEASE) begin
            idx_d   = WIDX_W'(req_i.entry_to_release[ENTRY_W-1:BIT_W]);
            rd_addr = WIDX_W'(req_i.entry_to_release[ENTRY_W-1:BIT_W]);
            if (rel_oob) begin
              done_d = 1'b1;
              rsp_d  = '0;
            end
          end else begin
            idx_d   = '0;
            rd_addr = '0;
            if (words_now == '0) begin
              done_d = 1'b1;
              rsp_d  = '0;
            end
          end
        end
      end
      ST_SCAN: begin
        case (verdict)
          SCAN_NEXT: begin
            if (next_avail) begin
              idx_d   = idx_q + WIDX_W'(1);
              rd_addr = idx_q + WIDX_W'(1);
            end else begin
              done_d = 1'b1;
              rsp_d  = '0;
            end
          end
          SCAN_TAKE: begin
            we                = 1'b1;
            wdata             = wd | (WORD_W'(1) << bit_idx);
            done_d            = 1'b1;
            rsp_d.granted     = 1'b1;
            rsp_d.entry       = ENTRY_W'(cur);
          end
          SCAN_FALLBACK: begin
            if (fb_ok) begin
              idx_d   = WIDX_W'(lo_q[RLOW_W-1:BIT_W]);
              rd_addr = WIDX_W'(lo_q[RLOW_W-1:BIT_W]);
            end else begin
              done_d = 1'b1;
              rsp_d  = '0;
            end
          end
          default: begin
            done_d = 1'b1;
            rsp_d  = '0;
          end
        endcase
      end
      ST_FALLBACK: begin
        done_d = 1'b1;
        if (|fb_free) begin
          we            = 1'b1;
          wdata         = wd | (WORD_W'(1) << fb_bit);
          rsp_d.granted = 1'b1;
          rsp_d.entry   = {lo_q[RLOW_W-1:BIT_W], fb_bit};
        end else begin
          rsp_d = '0;
        end
      end
      ST_RELEASE: begin
        we            = 1'b1;
        wdata         = wd & ~(WORD_W'(1) << rel_bit_q);
        done_d        = 1'b1;
        rsp_d.granted = 1'b1;
        rsp_d.entry   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      words_q <= '0;
      mode_q  <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      words_q <= words_d;
      mode_q  <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    rel_bit_q <= rel_bit_d;
    rsp_q     <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

>>> design/bmalloc_chk.sv
// port-level checker for the bitmap allocator, bound to the top level
`default_nettype none

module bmalloc_chk (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               start,
  input wire                               busy,
  input wire bmalloc_pkg::req_t            req_i,
  input wire                               done_o,
  input wire bmalloc_pkg::rsp_t            rsp_o,
  input wire                               cfg_we_i,
  input wire [bmalloc_pkg::CFGI_W-1:0]     cfg_idx_i,
  input wire [bmalloc_pkg::CFG_W-1:0]      cfg_wdata_i
);
  import bmalloc_pkg::*;

  // a failed beat carries no entry number
  a_fail_entry_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !rsp_o.granted |-> rsp_o.entry == '0)
    else $error("failed result with nonzero entry");

  // an accepted request either keeps the block busy or answers next cycle
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || done_o)
    else $error("accepted request neither busy nor answered");

  // busy only drops together with a result beat
  a_busy_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  // results leave only from the idle state
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

endmodule

bind bitmap_id_allocator_reserved_range bmalloc_chk u_bmalloc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .req_i       (req_i),
  .done_o      (done_o),
  .rsp_o       (rsp_o),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_wdata_i (cfg_wdata_i)
);

`default_nettype wire

>>> test/bitmap_id_allocator_reserved_range_checker.sv
// checker for the bitmap allocator: tracks the bitmap and registers, predicts and compares results
module bitmap_id_allocator_reserved_range_checker #(
  parameter int unsigned MAX_ENTRIES = 1024
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             start_i,
  input  wire                             busy_i,
  input  bmalloc_pkg::req_t               req_i,
  input  wire                             done_i,
  input  bmalloc_pkg::rsp_t               rsp_i,
  input  wire                             cfg_we_i,
  input  wire [bmalloc_pkg::CFGI_W-1:0]   cfg_idx_i,
  input  wire [bmalloc_pkg::CFG_W-1:0]    cfg_wdata_i,
  output int                              pending_o,
  output int                              fail_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bmalloc_pkg::*;

  localparam int unsigned NUM_WORDS = MAX_ENTRIES / WORD_W;
  localparam int unsigned NO_BIT    = WORD_W;

  logic [WORD_W-1:0]  used_map [NUM_WORDS];
  logic [SIZE_W-1:0]  n_entries;
  logic [RLOW_W-1:0]  rsv_lo;
  logic [RHIGH_W-1:0] rsv_hi;
  rsp_t               grants_due [$];
  int                 n_bad;

  // lowest clear bit of word among the allowed bits, NO_BIT if none
  function automatic int unsigned first_free(logic [WORD_W-1:0] word,
                                             logic [WORD_W-1:0] allowed);
    for (int b = 0; b < WORD_W; b++) begin
      if (allowed[b] && !word[b]) return b;
    end
    return NO_BIT;
  endfunction

  // applies one request to the tracked bitmap and returns the result it gives
  function automatic rsp_t grant_entry(req_t r);
    rsp_t              res;
    logic [WORD_W-1:0] allowed;
    int unsigned       nwords, span, b, cur, widx;
    res = '0;
    if (r.mode == MODE_RELEASE) begin
      used_map[r.entry_to_release[ENTRY_W-1:BIT_W]][r.entry_to_release[BIT_W-1:0]] = 1'b0;
      res.granted = 1'b1;
      return res;
    end
    nwords = (n_entries + 31) / WORD_W;
    if (nwords > NUM_WORDS) nwords = NUM_WORDS;
    for (int i = 0; i < nwords; i++) begin
      b = first_free(used_map[i], '1);
      if (b == NO_BIT) continue;
      widx = i;
      cur  = i * WORD_W + b;
      if (r.mode == MODE_WED) begin
        if (cur >= rsv_lo && cur < rsv_hi) continue;
        if (cur >= n_entries) begin
          // fall back to the word holding the start of the reserved range
          if (rsv_hi <= rsv_lo || (rsv_lo >> BIT_W) >= NUM_WORDS) return res;
          span = rsv_hi - rsv_lo;
          if (span > WORD_W) span = WORD_W;
          allowed = (span == WORD_W) ? '1 : ((32'd1 << span) - 32'd1);
          widx = rsv_lo >> BIT_W;
          b = first_free(used_map[widx], allowed);
          if (b == NO_BIT) return res;
          cur = widx * WORD_W + b;
        end
      end else if (r.mode == MODE_WDS) begin
        if (cur < rsv_lo) continue;
        if (cur >= rsv_hi) return res;
      end else if (cur >= n_entries) begin
        return res;
      end
      used_map[widx][b] = 1'b1;
      res.granted = 1'b1;
      res.entry   = cur[ENTRY_W-1:0];
      return res;
    end
    return res;
  endfunction

  task automatic flag(string what, rsp_t want, rsp_t got);
    n_bad++;
    if (n_bad <= 10) begin
      $display("%0t: %s: expected granted=%0d entry=%0d, got granted=%0d entry=%0d",
               $realtime, what, want.granted, want.entry, got.granted, got.entry);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_WORDS; i++) used_map[i] = '0;
      n_entries = RST_ENTRIES_IN_USE;
      rsv_lo    = RST_RESERVED_LOW;
      rsv_hi    = RST_RESERVED_HIGH;
      grants_due.delete();
      n_bad     = 0;
      pending_o <= 0;
      fail_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ENTRIES_IN_USE: n_entries = cfg_wdata_i[SIZE_W-1:0];
          CFG_RESERVED_LOW:   rsv_lo    = cfg_wdata_i[RLOW_W-1:0];
          CFG_RESERVED_HIGH:  rsv_hi    = cfg_wdata_i[RHIGH_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) grants_due.push_back(grant_entry(req_i));
      if (done_i) begin
        if (grants_due.size() == 0) begin
          flag("result beat with nothing expected", '0, rsp_i);
        end else begin
          want = grants_due.pop_front();
          if (want.granted !== rsp_i.granted || want.entry !== rsp_i.entry) begin
            flag("result mismatch", want, rsp_i);
          end
        end
      end
      pending_o <= grants_due.size();
      fail_o    <= n_bad;
    end
  end

endmodule

>>> test/bitmap_id_allocator_reserved_range_test.sv
// top of the allocator testbench: clock, reset, requests, register writes and verdict
module bitmap_id_allocator_reserved_range_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bmalloc_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PHASES      = 14;
  localparam int unsigned PHASE_ITEMS = 140;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              start     = 1'b0;
  req_t              req       = '0;
  logic              cfg_we    = 1'b0;
  logic [CFGI_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              busy;
  logic              done;
  rsp_t              rsp;
  int                pend;
  int                fails;
  int unsigned       quiet     = 0;
  int unsigned       calm_left = 0;

  // register values in force, used to aim releases
  int unsigned cur_size = RST_ENTRIES_IN_USE;
  int unsigned cur_lo   = RST_RESERVED_LOW;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bitmap_id_allocator_reserved_range u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .done_o      (done),
    .rsp_o       (rsp),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  bitmap_id_allocator_reserved_range_checker u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (req),
    .done_i      (done),
    .rsp_i       (rsp),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pending_o   (pend),
    .fail_o      (fails)
  );

  always @(posedge clk) begin
    if ((start && !busy) || done || cfg_we) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic req_t mk(mode_e m, int unsigned e);
    req_t r;
    r.mode             = m;
    r.entry_to_release = e[ENTRY_W-1:0];
    return r;
  endfunction

  function automatic req_t pick_item();
    int unsigned roll, hint, e;
    roll = $urandom_range(0, 99);
    e    = $urandom_range(0, 1023);
    if (roll < 25) return mk(MODE_PLAIN, e);
    if (roll < 45) return mk(MODE_WED, e);
    if (roll < 60) return mk(MODE_WDS, e);
    // releases mostly land where allocations happen
    roll = $urandom_range(0, 3);
    if (roll < 2) begin
      hint = (cur_size + 31 > 1023) ? 1023 : cur_size + 31;
      e = $urandom_range(0, hint);
    end else if (roll == 2) begin
      e = (cur_lo / 32) * 32 + $urandom_range(0, 40);
      if (e > 1023) e = 1023;
    end
    return mk(MODE_RELEASE, e);
  endfunction

  task automatic send(req_t r);
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // gap after a beat: random, none in calm stretches, sometimes a full drain
  task automatic pace();
    int unsigned gap;
    bit          drain;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 19);
      if ($urandom_range(0, 9) == 0) calm_left = $urandom_range(10, 40);
    end
    drain = ($urandom_range(0, 49) == 0);
    if (gap > 0 || drain) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain) begin
        @(posedge clk);
        while (pend != 0) @(posedge clk);
      end
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pend != 0 || busy);
  endtask

  task automatic put_reg(cfg_idx_e idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    @(posedge clk);
  endtask

  task automatic apply(int unsigned sz, int unsigned lo, int unsigned hi);
    put_reg(CFG_ENTRIES_IN_USE, sz);
    put_reg(CFG_RESERVED_LOW, lo);
    put_reg(CFG_RESERVED_HIGH, hi);
    cfg_we   <= 1'b0;
    cur_size = sz;
    cur_lo   = lo % 1024;
  endtask

  task automatic setting_for(int k, output int unsigned sz, output int unsigned lo,
                             output int unsigned hi);
    case (k)
      1:  begin sz = 40;   lo = 64;   hi = 80;   end  // fallback past entries in use
      2:  begin sz = 1024; lo = 0;    hi = 32;   end
      3:  begin sz = 1;    lo = 992;  hi = 1024; end
      4:  begin sz = 0;    lo = 256;  hi = 272;  end  // nothing to scan
      5:  begin sz = 100;  lo = 1120; hi = 200;  end  // wide range, low bit 10 dropped
      6:  begin sz = 64;   lo = 70;   hi = 90;   end  // unaligned range start
      7:  begin sz = 200;  lo = 128;  hi = 128;  end  // empty range
      8:  begin sz = 160;  lo = 100;  hi = 60;   end  // inverted range
      9:  begin sz = 2047; lo = 512;  hi = 2047; end
      10: begin sz = 96;   lo = 32;   hi = 64;   end
      11: begin sz = 1024; lo = 256;  hi = 272;  end
      default: begin
        sz = $urandom_range(1, 1024);
        lo = $urandom_range(0, 31) * 32;
        if ($urandom_range(0, 3) == 0) lo += $urandom_range(1, 31);
        hi = lo + $urandom_range(0, 48);
      end
    endcase
  endtask

  initial begin
    int unsigned sz, lo, hi;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // reset register values, hand-picked requests
    send(mk(MODE_PLAIN, 0));      pace();
    send(mk(MODE_PLAIN, 1023));   pace();
    send(mk(MODE_WED, 0));        pace();
    send(mk(MODE_WDS, 0));        pace();
    send(mk(MODE_WDS, 341));      pace();
    send(mk(MODE_RELEASE, 1023)); pace();  // entry already free
    send(mk(MODE_RELEASE, 0));    pace();
    send(mk(MODE_WED, 682));      pace();
    send(mk(MODE_RELEASE, 256));  pace();
    send(mk(MODE_WDS, 0));        pace();
    send(mk(MODE_RELEASE, 341));  pace();
    send(mk(MODE_RELEASE, 682));  pace();
    send(mk(MODE_PLAIN, 0));      pace();
    for (int k = 1; k <= PHASES; k++) begin
      settle();
      setting_for(k, sz, lo, hi);
      apply(sz, lo, hi);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send(pick_item());
        pace();
      end
    end
    settle();
    repeat (40) @(posedge clk);
    if (fails == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
